/* src/rpn_pkg.sv */
package rpn_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DEPTH_W   = 5;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned DIV_STEPS = 33;

  localparam logic [KIND_W-1:0] KIND_PUSH  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_SUB   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_MUL   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_DIV   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_REM   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_DUP   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SWAP  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 4'd8;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_DIV = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FEW      = 3'd4;

  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    logic [STATUS_W-1:0]      status;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_REM
  } op_t;

  typedef enum logic [2:0] {
    CM_NONE,
    CM_PUSH,
    CM_DUP,
    CM_BIN,
    CM_POP,
    CM_CLEAR,
    CM_SWAP1,
    CM_SWAP2
  } commit_t;

  typedef struct packed {
    logic    load_in;
    logic    read;
    logic    load_a;
    logic    mul;
    logic    div_start;
    op_t     op;
    commit_t commit;
  } cmd_t;

  typedef struct packed {
    logic                     empty;
    logic                     has_two;
    logic                     full;
    logic                     b_zero;
    logic                     b_int_zero;
    logic                     div_busy;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
  } stat_t;

  function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (~x + 32'd1) : x;
  endfunction

  // Applies a sign to a magnitude and clamps it to the 32-bit range.
  function automatic logic [DATA_W-1:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [63:0] n;
    n = 64'd0 - mag;
    if (neg) begin
      return (mag > 64'h8000_0000) ? VAL_MIN : n[DATA_W-1:0];
    end else begin
      return (mag > 64'h7fff_ffff) ? VAL_MAX : mag[DATA_W-1:0];
    end
  endfunction

  function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W:0] s);
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? VAL_MIN : VAL_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

/* src/rpn_stack_calculator.sv */
// Reverse Polish calculator stack engine on signed fixed-point words (FRACTION_BITS
// fraction bits). Each accepted command yields exactly one result with the new top of
// stack, the depth and a status. The block works on one command at a time; divide and
// remainder use a shift-subtract divider that retires one quotient bit per cycle over
// 33 steps. The stack lives in a single-port-write RAM with a registered read, with the
// top value cached in a register. The result register lets the next command enter
// while a result is still stalled.
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rpn_pkg::out_item_t out_data
);

  rpn_pkg::cmd_t  cmd;
  rpn_pkg::stat_t st;

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_data.kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

  rpn_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .st      (st)
  );

endmodule

/* src/rpn_ram.sv */
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/rpn_div.sv */
module rpn_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [32:0] quot,
  output logic [31:0] rem
);

  localparam int unsigned CNT_W = $clog2(rpn_pkg::DIV_STEPS + 1);

  logic [31:0]      rem_r;
  logic [32:0]      quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             fits;

  // The upper dividend bits start as the partial remainder; one quotient bit per cycle.
  assign trial = {rem_r, quo_r[32]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(rpn_pkg::DIV_STEPS);
      rem_r  <= {1'b0, dividend[63:33]};
      quo_r  <= dividend[32:0];
    end else if (busy_r) begin
      rem_r <= fits ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[31:0], fits};
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

/* src/rpn_datapath.sv */
module rpn_datapath #(
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::in_item_t in_data,
  input  rpn_pkg::cmd_t     cmd,
  output rpn_pkg::stat_t    st
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [31:0]   top_r;
  logic [31:0]   top_nxt;
  logic [31:0]   opnd_r;
  logic [31:0]   a_r;
  logic [63:0]   prod_r;
  logic          ovf_r;

  logic          empty;
  logic          has_two;
  logic [31:0]   b_val;
  logic [31:0]   a_mag;
  logic [31:0]   b_mag;
  logic [31:0]   a_int;
  logic [31:0]   b_int;
  logic          neg;
  logic [CW-1:0] bin_idx;
  logic [63:0]   dvd;
  logic [31:0]   dvs;
  logic          div_busy;
  logic [32:0]   quot;
  logic [31:0]   rem;
  logic [31:0]   rem_signed;
  logic [32:0]   sum;
  logic [32:0]   dif;
  logic [31:0]   res;
  logic [31:0]   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  assign empty   = (count_r == '0);
  assign has_two = (count_r >= CW'(2));
  assign b_val   = empty ? 32'd0 : top_r;
  assign a_mag   = rpn_pkg::abs32(a_r);
  assign b_mag   = rpn_pkg::abs32(b_val);
  assign a_int   = a_mag >> FRACTION_BITS;
  assign b_int   = b_mag >> FRACTION_BITS;
  assign neg     = a_r[31] ^ b_val[31];
  assign bin_idx = has_two ? (count_r - CW'(2)) : '0;

  always_comb begin
    if (cmd.op == rpn_pkg::OP_DIV) begin
      dvd = {32'd0, a_mag} << FRACTION_BITS;
      dvs = b_mag;
    end else begin
      dvd = {32'd0, a_int};
      dvs = b_int;
    end
  end

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  assign sum        = {a_r[31], a_r} + {b_val[31], b_val};
  assign dif        = {a_r[31], a_r} - {b_val[31], b_val};
  assign rem_signed = a_r[31] ? (32'd0 - rem) : rem;

  always_comb begin
    case (cmd.op)
      rpn_pkg::OP_ADD: res = rpn_pkg::sat_sum(sum);
      rpn_pkg::OP_SUB: res = rpn_pkg::sat_sum(dif);
      rpn_pkg::OP_MUL: res = rpn_pkg::sat_mag(neg, prod_r >> FRACTION_BITS);
      rpn_pkg::OP_DIV: begin
        if (ovf_r) begin
          res = neg ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
        end else begin
          res = rpn_pkg::sat_mag(neg, {31'd0, quot});
        end
      end
      rpn_pkg::OP_REM: res = rem_signed << FRACTION_BITS;
      default:         res = 32'd0;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    wr_en     = 1'b0;
    wr_addr   = AW'(count_r);
    wr_data   = top_r;
    unique case (cmd.commit)
      rpn_pkg::CM_PUSH: begin
        wr_en     = 1'b1;
        wr_data   = opnd_r;
        top_nxt   = opnd_r;
        count_nxt = count_r + CW'(1);
      end
      rpn_pkg::CM_DUP: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
      end
      rpn_pkg::CM_BIN: begin
        wr_en     = 1'b1;
        wr_addr   = AW'(bin_idx);
        wr_data   = res;
        top_nxt   = res;
        count_nxt = bin_idx + CW'(1);
      end
      rpn_pkg::CM_POP: begin
        top_nxt   = a_r;
        count_nxt = count_r - CW'(1);
      end
      rpn_pkg::CM_CLEAR: count_nxt = '0;
      rpn_pkg::CM_SWAP1: begin
        wr_en   = 1'b1;
        wr_addr = AW'(count_r - CW'(2));
      end
      rpn_pkg::CM_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = AW'(count_r - CW'(1));
        wr_data = a_r;
        top_nxt = a_r;
      end
      default: ;
    endcase
  end

  rpn_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.read),
    .rd_addr (AW'(count_r - CW'(2))),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (cmd.load_in) begin
      opnd_r <= in_data.operand;
    end
    // The second value is taken from the RAM only when it exists; otherwise the pop reads zero.
    if (cmd.load_a) begin
      a_r <= has_two ? rd_data : 32'd0;
    end
    if (cmd.mul) begin
      prod_r <= a_mag * b_mag;
    end
    if (cmd.div_start) begin
      ovf_r <= ({1'b0, dvd[63:33]} >= dvs);
    end
  end

  assign st.empty      = empty;
  assign st.has_two    = has_two;
  assign st.full       = (count_r == CW'(STACK_DEPTH));
  assign st.b_zero     = (b_val == 32'd0);
  assign st.b_int_zero = (b_int == 32'd0);
  assign st.div_busy   = div_busy;
  assign st.top_value  = b_val;
  assign st.depth      = rpn_pkg::DEPTH_W'(count_r);

endmodule

/* src/rpn_ctrl.sv */
module rpn_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rpn_pkg::KIND_W-1:0]      in_kind,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rpn_pkg::out_item_t              out_data,
  output rpn_pkg::cmd_t                   cmd,
  input  rpn_pkg::stat_t                  st
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOADA,
    S_MULT,
    S_DIVGO,
    S_DIVWAIT,
    S_COMMIT,
    S_SWAP1,
    S_SWAP2,
    S_FINISH
  } state_t;

  state_t                          state_r, state_nxt;
  logic [rpn_pkg::KIND_W-1:0]      kind_r, kind_nxt;
  logic [rpn_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic                            zdiv_r, zdiv_nxt;
  logic                            out_valid_r, out_valid_nxt;
  rpn_pkg::out_item_t              out_data_r, out_data_nxt;
  rpn_pkg::op_t                    op;
  logic                            div_zero;

  always_comb begin
    unique case (kind_r) inside
      rpn_pkg::KIND_SUB: op = rpn_pkg::OP_SUB;
      rpn_pkg::KIND_MUL: op = rpn_pkg::OP_MUL;
      rpn_pkg::KIND_DIV: op = rpn_pkg::OP_DIV;
      rpn_pkg::KIND_REM: op = rpn_pkg::OP_REM;
      default:           op = rpn_pkg::OP_ADD;
    endcase
  end

  assign div_zero = (kind_r == rpn_pkg::KIND_DIV) ? st.b_zero : st.b_int_zero;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    status_nxt    = status_r;
    zdiv_nxt      = zdiv_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd           = '0;
    cmd.op        = op;
    cmd.commit    = rpn_pkg::CM_NONE;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          cmd.load_in = 1'b1;
          status_nxt  = rpn_pkg::ST_OK;
          zdiv_nxt    = 1'b0;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        unique case (kind_r) inside
          rpn_pkg::KIND_PUSH: begin
            if (st.full) begin
              status_nxt = rpn_pkg::ST_FULL;
            end else begin
              cmd.commit = rpn_pkg::CM_PUSH;
            end
          end
          rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB, rpn_pkg::KIND_MUL: begin
            cmd.read  = 1'b1;
            state_nxt = S_LOADA;
            if (!st.has_two) begin
              status_nxt = rpn_pkg::ST_EMPTY;
            end
          end
          rpn_pkg::KIND_DIV, rpn_pkg::KIND_REM: begin
            if (st.empty) begin
              status_nxt = rpn_pkg::ST_EMPTY;
            end else begin
              // A zero divisor is still popped, so the value below it is fetched as new top.
              cmd.read  = 1'b1;
              state_nxt = S_LOADA;
              if (div_zero) begin
                status_nxt = rpn_pkg::ST_ZERO_DIV;
                zdiv_nxt   = 1'b1;
              end else if (!st.has_two) begin
                status_nxt = rpn_pkg::ST_EMPTY;
              end
            end
          end
          rpn_pkg::KIND_DUP: begin
            if (st.empty) begin
              status_nxt = rpn_pkg::ST_EMPTY;
            end else if (st.full) begin
              status_nxt = rpn_pkg::ST_FULL;
            end else begin
              cmd.commit = rpn_pkg::CM_DUP;
            end
          end
          rpn_pkg::KIND_SWAP: begin
            if (!st.has_two) begin
              status_nxt = rpn_pkg::ST_FEW;
            end else begin
              cmd.read  = 1'b1;
              state_nxt = S_LOADA;
            end
          end
          rpn_pkg::KIND_CLEAR: cmd.commit = rpn_pkg::CM_CLEAR;
          rpn_pkg::KIND_PEEK: begin
            if (st.empty) begin
              status_nxt = rpn_pkg::ST_EMPTY;
            end
          end
          default: ;
        endcase
      end
      S_LOADA: begin
        cmd.load_a = 1'b1;
        unique case (kind_r) inside
          rpn_pkg::KIND_MUL:                    state_nxt = S_MULT;
          rpn_pkg::KIND_DIV, rpn_pkg::KIND_REM: state_nxt = zdiv_r ? S_COMMIT : S_DIVGO;
          rpn_pkg::KIND_SWAP:                   state_nxt = S_SWAP1;
          default:                              state_nxt = S_COMMIT;
        endcase
      end
      S_MULT: begin
        cmd.mul   = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (!st.div_busy) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = zdiv_r ? rpn_pkg::CM_POP : rpn_pkg::CM_BIN;
        state_nxt  = S_FINISH;
      end
      S_SWAP1: begin
        cmd.commit = rpn_pkg::CM_SWAP1;
        state_nxt  = S_SWAP2;
      end
      S_SWAP2: begin
        cmd.commit = rpn_pkg::CM_SWAP2;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.top_value = st.top_value;
          out_data_nxt.depth     = st.depth;
          out_data_nxt.status    = status_r;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      status_r    <= status_nxt;
      zdiv_r      <= zdiv_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/rpn_checker.sv */
module rpn_stack_calculator_sva #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input rpn_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input rpn_pkg::out_item_t out_data
);

  // One command at a time: a transfer closes the input until its result is formed.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= rpn_pkg::ST_FEW))
    else $error("status code out of range");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (STACK_DEPTH < 32) && (out_data.depth == '0)) |->
      (out_data.top_value == '0))
    else $error("empty stack reports a nonzero top");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == rpn_pkg::ST_FEW)) |->
      ((STACK_DEPTH >= 32) || (out_data.depth < 5'd2)))
    else $error("swap refused with two or more values");

endmodule

bind rpn_stack_calculator rpn_stack_calculator_sva #(.STACK_DEPTH(STACK_DEPTH)) u_rpn_sva (.*);

/* bench/rpn_checker.sv */
module rpn_checker
  import rpn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = 16;
  localparam longint SCALE = 64'sd65536;

  logic signed [31:0] stk [NSLOTS];
  int                 cnt;
  out_item_t          expected_q[$];

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] pop_val(inout bit was_empty);
    if (cnt > 0) begin
      cnt--;
      return stk[cnt];
    end
    was_empty = 1;
    return 0;
  endfunction

  function automatic void push_val(logic signed [31:0] v);
    if (cnt < NSLOTS) begin
      stk[cnt] = v;
      cnt++;
    end
  endfunction

  function automatic out_item_t compute_stack(in_item_t it);
    logic [2:0]         st;
    bit                 emp;
    logic signed [31:0] a, b, t;
    longint             ai, bi;
    out_item_t          r;
    st = ST_OK;
    emp = 0;
    case (it.kind)
      KIND_PUSH: begin
        if (cnt < NSLOTS) push_val(it.operand);
        else st = ST_FULL;
      end
      KIND_ADD, KIND_SUB, KIND_MUL: begin
        b = pop_val(emp);
        a = pop_val(emp);
        if (it.kind == KIND_ADD) push_val(clamp32(longint'(a) + longint'(b)));
        else if (it.kind == KIND_SUB) push_val(clamp32(longint'(a) - longint'(b)));
        else push_val(clamp32((longint'(a) * longint'(b)) / SCALE));
        if (emp) st = ST_EMPTY;
      end
      KIND_DIV, KIND_REM: begin
        b = pop_val(emp);
        if (emp) st = ST_EMPTY;
        else if (it.kind == KIND_DIV) begin
          if (b == 0) st = ST_ZERO_DIV;
          else begin
            a = pop_val(emp);
            push_val(clamp32((longint'(a) * SCALE) / longint'(b)));
            if (emp) st = ST_EMPTY;
          end
        end else begin
          bi = longint'(b) / SCALE;
          if (bi == 0) st = ST_ZERO_DIV;
          else begin
            a = pop_val(emp);
            ai = longint'(a) / SCALE;
            push_val(clamp32((ai % bi) * SCALE));
            if (emp) st = ST_EMPTY;
          end
        end
      end
      KIND_DUP: begin
        if (cnt == 0) st = ST_EMPTY;
        else if (cnt >= NSLOTS) st = ST_FULL;
        else push_val(stk[cnt-1]);
      end
      KIND_SWAP: begin
        if (cnt < 2) st = ST_FEW;
        else begin
          t = stk[cnt-1];
          stk[cnt-1] = stk[cnt-2];
          stk[cnt-2] = t;
        end
      end
      KIND_CLEAR: cnt = 0;
      KIND_PEEK: if (cnt == 0) st = ST_EMPTY;
      default: ;
    endcase
    r.top_value = (cnt > 0) ? stk[cnt-1] : 32'sd0;
    r.depth = cnt[4:0];
    r.status = st;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      cnt <= 0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: exp top=%h depth=%0d st=%0d, got top=%h depth=%0d st=%0d",
                       e.top_value, e.depth, e.status,
                       out_data.top_value, out_data.depth, out_data.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(compute_stack(in_data));
    end
  end
endmodule

/* bench/tb_top.sv */
module tb_top;
  import rpn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycles = 0;
  bit        hold_long = 0;
  int        depth_est = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  rpn_stack_calculator dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  rpn_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stall per transfer, plus one long hold-off.
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        hold_long = 0;
        out_stall <= 0;
      end else if (out_valid && !out_stall) begin
        w = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
        if (w > 0) begin
          out_stall <= 1;
          repeat (w) @(posedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return $signed({$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'h0})
                + $signed({16'($urandom_range(0, 20)), 16'h0});
      4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [3:0] k, logic signed [31:0] v);
    int gap;
    in_valid <= 1;
    in_data.kind <= k;
    in_data.operand <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [3:0] k;
    int i;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: empty cases, extremes, saturation, zero divisors, full stack.
    send(KIND_PEEK, 0);
    send(KIND_DUP, 0);
    send(KIND_ADD, 0);
    send(KIND_DIV, 0);
    send(KIND_SWAP, 0);
    send(KIND_PUSH, 32'sh7fffffff);
    send(KIND_PUSH, 32'sh7fffffff);
    send(KIND_ADD, 0);
    send(KIND_PUSH, 32'sh80000000);
    send(KIND_MUL, 0);
    send(KIND_PUSH, 32'sh00008000);
    send(KIND_DIV, 0);
    send(KIND_PUSH, 0);
    send(KIND_DIV, 0);
    send(KIND_PUSH, 32'sh00004000);
    send(KIND_REM, 0);
    send(KIND_PUSH, 32'shfffd0000);
    send(KIND_PUSH, 32'sh00020000);
    send(KIND_REM, 0);
    send(KIND_SUB, 0);
    send(KIND_SWAP, 0);
    for (i = 0; i < 17; i++) send(KIND_DUP, 0);
    send(KIND_PUSH, 32'sh12345678);
    send(KIND_CLEAR, 0);
    send(4'hf, 32'shffffffff);
    for (i = 0; i < 1000; i++) begin
      if (i == 500) hold_long = 1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: k = KIND_PUSH;
        6: k = (depth_est > 4) ? KIND_CLEAR : KIND_PUSH;
        7: k = 4'($urandom_range(10, 15));
        default: k = 4'($urandom_range(1, 9));
      endcase
      if (k == KIND_CLEAR && $urandom_range(0, 3) != 0) k = KIND_DUP;
      if (k == KIND_PUSH || k == KIND_DUP) depth_est++;
      else if (k == KIND_CLEAR) depth_est = 0;
      else if (k >= KIND_ADD && k <= KIND_REM && depth_est > 0) depth_est--;
      send(k, (k == KIND_PUSH) ? rand_val() : $signed($urandom));
    end
    in_valid <= 0;
    while (pending != 0 || hold_long) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
